>>> hdl/deq_pkg.sv
// shared types, codes and sizes for the double-ended queue
// no dependencies; used by every module of the block
package deq_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int VAL_W = 32;

    // action codes on the input request
    localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [2:0] ACT_POP_BACK   = 3'd3;
    localparam logic [2:0] ACT_SEARCH     = 3'd4;
    localparam logic [2:0] ACT_CLEAR      = 3'd5;

    // status codes on the result
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // cell operation codes, already qualified by full and empty
    localparam logic [2:0] OP_NOP        = 3'd0;
    localparam logic [2:0] OP_SHIFT_IN   = 3'd1;
    localparam logic [2:0] OP_FILL_TAIL  = 3'd2;
    localparam logic [2:0] OP_SHIFT_OUT  = 3'd3;
    localparam logic [2:0] OP_DROP_TAIL  = 3'd4;
    localparam logic [2:0] OP_MATCH      = 3'd5;
    localparam logic [2:0] OP_FLUSH      = 3'd6;

    typedef struct packed {
        logic [2:0]       op;
        logic [VAL_W-1:0] value;
    } cell_cmd_t;

endpackage

>>> hdl/deq_cell.sv
// one storage cell of the queue chain: value, valid bit and search match bit
// depends on deq_pkg
module deq_cell (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  deq_pkg::cell_cmd_t       cmd,
    input  logic [deq_pkg::VAL_W-1:0] left_val,
    input  logic                     left_valid,
    input  logic [deq_pkg::VAL_W-1:0] right_val,
    input  logic                     right_valid,
    output logic [deq_pkg::VAL_W-1:0] val_reg,
    output logic                     valid_reg,
    output logic                     match_reg
);

    logic [deq_pkg::VAL_W-1:0] val_next;
    logic                      valid_next;
    logic                      match_next;

    always_comb begin
        val_next   = val_reg;
        valid_next = valid_reg;
        match_next = 1'b0;
        case (cmd.op)
            deq_pkg::OP_SHIFT_IN: begin
                val_next   = left_val;
                valid_next = left_valid;
            end
            deq_pkg::OP_FILL_TAIL: begin
                // the first free cell, behind the last used one or cell 0 of an empty row, takes the new value
                if (!valid_reg && left_valid) begin
                    val_next   = cmd.value;
                    valid_next = 1'b1;
                end
            end
            deq_pkg::OP_SHIFT_OUT: begin
                val_next   = right_val;
                valid_next = right_valid;
            end
            deq_pkg::OP_DROP_TAIL: begin
                if (valid_reg && !right_valid) begin
                    valid_next = 1'b0;
                end
            end
            deq_pkg::OP_MATCH: begin
                match_next = valid_reg && (val_reg == cmd.value);
            end
            deq_pkg::OP_FLUSH: begin
                valid_next = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
        val_reg <= val_next;
    end

endmodule

>>> hdl/deq_collect.sv
// gathers front value, back value and search outcome from the cell row
// depends on deq_pkg
module deq_collect (
    input  logic [deq_pkg::VAL_W-1:0] cell_val [deq_pkg::DEPTH],
    input  logic [deq_pkg::DEPTH-1:0] cell_valid,
    input  logic [deq_pkg::DEPTH-1:0] cell_match,
    output logic [deq_pkg::VAL_W-1:0] front_value,
    output logic [deq_pkg::VAL_W-1:0] back_value,
    output logic                      found
);

    logic [deq_pkg::DEPTH-1:0] is_tail;

    // tail cell is the last valid one; the row is always packed from cell 0
    always_comb begin
        for (int i = 0; i < deq_pkg::DEPTH - 1; i++) begin
            is_tail[i] = cell_valid[i] && !cell_valid[i+1];
        end
        is_tail[deq_pkg::DEPTH-1] = cell_valid[deq_pkg::DEPTH-1];
    end

    always_comb begin
        back_value = '0;
        for (int i = 0; i < deq_pkg::DEPTH; i++) begin
            back_value = back_value | (cell_val[i] & {deq_pkg::VAL_W{is_tail[i]}});
        end
    end

    assign front_value = cell_valid[0] ? cell_val[0] : '0;
    assign found       = |cell_match;

endmodule

>>> hdl/double_ended_queue_core.sv
// top level of the bounded double-ended queue of signed 32-bit values
// depends on deq_pkg, deq_cell, deq_collect
//
// The queue is a row of DEPTH cells, cell 0 holding the front value. A push
// at the front shifts the whole row one cell back, a pop at the front shifts
// it one cell forward, a push at the back fills the first free cell and a pop
// at the back frees the last used one; a search has every cell compare its
// value at once. Each input request yields exactly one result. A request
// proceeds thus: in the cycle it is accepted the cells update, in the next
// the front, back and search results are gathered from the row into the
// output register. A new request is accepted only after the previous one is
// gathered and while the result side keeps up; the next may be accepted while
// the previous result is still being taken. A push onto a full queue returns
// status 1, a pop from an empty one status 2; both leave the queue as it was.
// Action codes 6 and 7 change nothing and report the current contents.
// No clearing pass runs after reset: the valid bits clear at once.
module double_ended_queue_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // action[2:0], value[34:3], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata    // status[1:0], front_value[33:2], back_value[65:34],
                                   // count[70:66], empty_flag[71], found[72], zero fill
);

    localparam logic [deq_pkg::CNT_W-1:0] CNT_FULL = deq_pkg::CNT_W'(deq_pkg::DEPTH);
    localparam logic [deq_pkg::CNT_W-1:0] CNT_ONE  = deq_pkg::CNT_W'(1);

    // request fields
    logic [2:0]                action;
    logic [deq_pkg::VAL_W-1:0] value;

    assign action = s_tdata[2:0];
    assign value  = s_tdata[34:3];

    // control registers
    logic                      busy_reg;
    logic                      busy_next;
    logic [deq_pkg::CNT_W-1:0] count_reg;
    logic [deq_pkg::CNT_W-1:0] count_next;
    logic [1:0]                status_reg;
    logic [1:0]                status_next;
    logic                      m_valid_reg;
    logic                      m_valid_next;
    logic [79:0]               m_data_reg;
    logic [79:0]               m_data_next;

    logic                      accept;
    logic                      full;
    logic                      empty;
    deq_pkg::cell_cmd_t        cmd;
    logic [1:0]                req_status;

    // one request in flight at a time; the output register frees up on take
    // nothing is taken while reset is held
    assign s_tready = aresetn && !busy_reg && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);

    // turn the action into a cell command, refusing pushes when full and pops when empty
    always_comb begin
        cmd.value  = value;
        cmd.op     = deq_pkg::OP_NOP;
        req_status = deq_pkg::ST_OK;
        count_next = count_reg;
        if (accept) begin
            case (action)
                deq_pkg::ACT_PUSH_FRONT: begin
                    if (full) begin
                        req_status = deq_pkg::ST_FULL;
                    end else begin
                        cmd.op     = deq_pkg::OP_SHIFT_IN;
                        count_next = count_reg + CNT_ONE;
                    end
                end
                deq_pkg::ACT_PUSH_BACK: begin
                    if (full) begin
                        req_status = deq_pkg::ST_FULL;
                    end else begin
                        cmd.op     = deq_pkg::OP_FILL_TAIL;
                        count_next = count_reg + CNT_ONE;
                    end
                end
                deq_pkg::ACT_POP_FRONT: begin
                    if (empty) begin
                        req_status = deq_pkg::ST_EMPTY;
                    end else begin
                        cmd.op     = deq_pkg::OP_SHIFT_OUT;
                        count_next = count_reg - CNT_ONE;
                    end
                end
                deq_pkg::ACT_POP_BACK: begin
                    if (empty) begin
                        req_status = deq_pkg::ST_EMPTY;
                    end else begin
                        cmd.op     = deq_pkg::OP_DROP_TAIL;
                        count_next = count_reg - CNT_ONE;
                    end
                end
                deq_pkg::ACT_SEARCH: begin
                    cmd.op = deq_pkg::OP_MATCH;
                end
                deq_pkg::ACT_CLEAR: begin
                    cmd.op     = deq_pkg::OP_FLUSH;
                    count_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    // cell row
    logic [deq_pkg::VAL_W-1:0] cell_val [deq_pkg::DEPTH];
    logic [deq_pkg::DEPTH-1:0] cell_valid;
    logic [deq_pkg::DEPTH-1:0] cell_match;

    genvar g;
    generate
        for (g = 0; g < deq_pkg::DEPTH; g++) begin : g_cell
            logic [deq_pkg::VAL_W-1:0] lv;
            logic                      lvalid;
            logic [deq_pkg::VAL_W-1:0] rv;
            logic                      rvalid;

            // cell 0 sees the pushed value on its front side, the last cell an empty one behind
            if (g == 0) begin : g_head
                assign lv     = value;
                assign lvalid = 1'b1;
            end else begin : g_mid
                assign lv     = cell_val[g-1];
                assign lvalid = cell_valid[g-1];
            end
            if (g == deq_pkg::DEPTH - 1) begin : g_tail
                assign rv     = '0;
                assign rvalid = 1'b0;
            end else begin : g_body
                assign rv     = cell_val[g+1];
                assign rvalid = cell_valid[g+1];
            end

            deq_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .cmd         (cmd),
                .left_val    (lv),
                .left_valid  (lvalid),
                .right_val   (rv),
                .right_valid (rvalid),
                .val_reg     (cell_val[g]),
                .valid_reg   (cell_valid[g]),
                .match_reg   (cell_match[g])
            );
        end
    endgenerate

    // result gathering from the updated row
    logic [deq_pkg::VAL_W-1:0] front_value;
    logic [deq_pkg::VAL_W-1:0] back_value;
    logic                      found;
    logic [4:0]                count_out;
    logic                      empty_flag;

    deq_collect u_collect (
        .cell_val    (cell_val),
        .cell_valid  (cell_valid),
        .cell_match  (cell_match),
        .front_value (front_value),
        .back_value  (back_value),
        .found       (found)
    );

    // count field is reported masked to its width
    assign count_out  = 5'(count_reg);
    assign empty_flag = (count_reg == '0);

    always_comb begin
        busy_next    = accept;
        status_next  = accept ? req_status : status_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (busy_reg) begin
            m_valid_next = 1'b1;
            m_data_next  = {7'd0, found, empty_flag, count_out, back_value,
                            front_value, status_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        status_reg <= status_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

>>> hdl/deq_checker.sv
// port-level checks on the result stream of the queue, bound to the top level
// depends on deq_pkg and double_ended_queue_core
module deq_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [39:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata
);

    localparam logic [4:0] CNT_FULL = 5'(deq_pkg::DEPTH);

    logic [1:0] status;
    logic [4:0] count;
    logic       empty_flag;
    logic       found;
    logic       in_unused;

    assign status     = m_tdata[1:0];
    assign count      = m_tdata[70:66];
    assign empty_flag = m_tdata[71];
    assign found      = m_tdata[72];
    assign in_unused  = s_tvalid && s_tready && (s_tdata[39:35] != '0);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // an empty queue reports zero at both ends
    a_empty_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && empty_flag |-> m_tdata[65:2] == '0 && count == '0)
        else $error("empty result carries values");

    // a refused push only happens at full capacity
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && status == deq_pkg::ST_FULL |-> count == CNT_FULL && !empty_flag)
        else $error("push refused below capacity");

    // a refused pop only happens when empty, and a hit never carries an error
    a_pop_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (status == deq_pkg::ST_EMPTY || found) |->
            (found ? status == deq_pkg::ST_OK && !empty_flag : empty_flag))
        else $error("inconsistent status, found and empty flag");

    // result padding must stay zero, except in a cycle that accepts a request with nonzero unused bits
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[79:73] == '0 || in_unused)
        else $error("result padding not zero");

endmodule

bind double_ended_queue_core deq_checker u_deq_checker (.*);
